// ----- sv/two_queue_block_cache_tags_unit_assert.svh -----
// Assertion macros shared by the checker of the block cache tag unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TWO_QUEUE_BLOCK_CACHE_TAGS_UNIT_ASSERT_SVH
`define TWO_QUEUE_BLOCK_CACHE_TAGS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/qbc_pkg.sv -----
// Shared constants, codes and types of the block cache tag unit.
// Used by the top level, the list and the checker; depends on nothing.
package qbc_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int SLOT_W      = $clog2(NUM_ENTRIES);
    localparam int RANK_W      = SLOT_W;
    localparam int FILE_W      = 16;
    localparam int BLOCK_W     = 24;
    localparam int HITS_W      = 4;
    localparam int CMD_W       = 2;
    localparam int KIND_W      = 2;
    localparam int OUT_SLOT_W  = 5;

    localparam logic [HITS_W-1:0] PROMOTE_HITS = 4'd2;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SYNC  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WB    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

    // List update operations.
    localparam logic [1:0] LOP_NONE   = 2'd0;
    localparam logic [1:0] LOP_MOVE   = 2'd1;
    localparam logic [1:0] LOP_INSERT = 2'd2;
    localparam logic [1:0] LOP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic              to_hot;
    } list_cmd_t;

    // One memory word per slot.
    typedef struct packed {
        logic [FILE_W-1:0]  file;
        logic [BLOCK_W-1:0] block;
        logic               dirty;
        logic [HITS_W-1:0]  hits;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/two_queue_block_cache_tags_unit.sv -----
// A hit or a fetch waits on the slot-by-slot tag scan through the one read port of the
// tag memory. A flush or sync does one memory read per cached slot, in list order.
// Throughput: one request at a time; the next request is taken once this one is done.
// Reset: rst_n is asynchronous and clears all valid and list bits at once; no memory pass.
module two_queue_block_cache_tags_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [qbc_pkg::CMD_W-1:0]         cmd,
    input  logic [qbc_pkg::FILE_W-1:0]        file_id,
    input  logic [qbc_pkg::BLOCK_W-1:0]       block_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [qbc_pkg::KIND_W-1:0]        kind,
    output logic [qbc_pkg::FILE_W-1:0]        out_file_id,
    output logic [qbc_pkg::BLOCK_W-1:0]       out_block_offset,
    output logic [qbc_pkg::OUT_SLOT_W-1:0]    slot,
    output logic                              last
);
    import qbc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_HIT     = 4'd2;
    localparam logic [3:0] S_MISS    = 4'd3;
    localparam logic [3:0] S_FETCH   = 4'd4;
    localparam logic [3:0] S_FL_FIND = 4'd5;
    localparam logic [3:0] S_FL_READ = 4'd6;
    localparam logic [3:0] S_FL_END  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [FILE_W-1:0] file_reg, file_next;
    logic [BLOCK_W-1:0] block_reg, block_next;
    logic [SLOT_W-1:0] scan_addr_reg, scan_addr_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0] cmp_slot_reg, cmp_slot_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    entry_t            hit_entry_reg, hit_entry_next;
    logic              fl_hot_reg, fl_hot_next;
    logic [RANK_W-1:0] fl_rank_reg, fl_rank_next;
    logic [SLOT_W-1:0] fl_slot_reg, fl_slot_next;
    logic              fl_fetch_reg, fl_fetch_next;

    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [FILE_W-1:0]     ofile_reg, ofile_next;
    logic [BLOCK_W-1:0]    oblock_reg, oblock_next;
    logic [OUT_SLOT_W-1:0] oslot_reg, oslot_next;
    logic                  olast_reg, olast_next;

    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    list_cmd_t              lcmd;
    logic                   q_found, full;
    logic [SLOT_W-1:0]      q_slot, free_slot;
    logic [NUM_ENTRIES-1:0] valid_vec, hot_vec;

    logic              out_free;
    logic              tag_match;
    logic              hit_is_hot, promote;
    logic [HITS_W-1:0] new_hits;

    qbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qbc_list u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .lcmd      (lcmd),
        .q_hot     (fl_hot_reg),
        .q_rank    (fl_rank_reg),
        .q_found   (q_found),
        .q_slot    (q_slot),
        .free_slot (free_slot),
        .full      (full),
        .valid_vec (valid_vec),
        .hot_vec   (hot_vec)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign tag_match = cmp_vld_reg && valid_vec[cmp_slot_reg]
                       && ram_rdata.file == file_reg && ram_rdata.block == block_reg;

    // Hit bookkeeping for the slot found by the scan.
    assign hit_is_hot = hot_vec[hit_slot_reg];
    assign new_hits   = hit_entry_reg.hits + 1'b1;
    assign promote    = !hit_is_hot && new_hits == PROMOTE_HITS;

    // Request sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        file_next      = file_reg;
        block_next     = block_reg;
        scan_addr_next = scan_addr_reg;
        cmp_vld_next   = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        hit_slot_next  = hit_slot_reg;
        hit_entry_next = hit_entry_reg;
        fl_hot_next    = fl_hot_reg;
        fl_rank_next   = fl_rank_reg;
        fl_slot_next   = fl_slot_reg;
        fl_fetch_next  = fl_fetch_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        ofile_next     = ofile_reg;
        oblock_next    = oblock_reg;
        oslot_next     = oslot_reg;
        olast_next     = olast_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_slot_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = scan_addr_reg;
        lcmd           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = cmd;
                    file_next      = file_id;
                    block_next     = block_offset;
                    scan_addr_next = '0;
                    fl_hot_next    = 1'b0;
                    fl_rank_next   = '0;
                    fl_fetch_next  = 1'b0;
                    if (cmd == CMD_SYNC || cmd == CMD_FLUSH)
                    begin
                        state_next = S_FL_FIND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Read one slot per cycle, compare the previous one.
                ram_re         = 1'b1;
                ram_raddr      = scan_addr_reg;
                scan_addr_next = scan_addr_reg + 1'b1;
                cmp_vld_next   = 1'b1;
                cmp_slot_next  = scan_addr_reg;
                if (tag_match)
                begin
                    hit_slot_next  = cmp_slot_reg;
                    hit_entry_next = ram_rdata;
                    state_next     = S_HIT;
                end
                else if (cmp_vld_reg && cmp_slot_reg == SLOT_W'(NUM_ENTRIES - 1))
                begin
                    state_next = S_MISS;
                end
            end
            S_HIT:
            begin
                if (out_free)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = hit_slot_reg;
                    ram_wdata.file  = file_reg;
                    ram_wdata.block = block_reg;
                    ram_wdata.dirty = hit_entry_reg.dirty || cmd_reg == CMD_WRITE;
                    ram_wdata.hits  = hit_is_hot ? hit_entry_reg.hits : new_hits;
                    lcmd.op         = LOP_MOVE;
                    lcmd.slot       = hit_slot_reg;
                    lcmd.to_hot     = hit_is_hot || promote;
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_HIT;
                    ofile_next      = file_reg;
                    oblock_next     = block_reg;
                    oslot_next      = OUT_SLOT_W'(hit_slot_reg);
                    olast_next      = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (full)
                begin
                    fl_fetch_next = 1'b1;
                    state_next    = S_FL_FIND;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (out_free)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = free_slot;
                    ram_wdata.file  = file_reg;
                    ram_wdata.block = block_reg;
                    ram_wdata.dirty = (cmd_reg == CMD_WRITE);
                    ram_wdata.hits  = '0;
                    lcmd.op         = LOP_INSERT;
                    lcmd.slot       = free_slot;
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_FETCH;
                    ofile_next      = file_reg;
                    oblock_next     = block_reg;
                    oslot_next      = OUT_SLOT_W'(free_slot);
                    olast_next      = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FL_FIND:
            begin
                // Look up the slot at the current list position.
                if (q_found)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = q_slot;
                    fl_slot_next = q_slot;
                    state_next   = S_FL_READ;
                end
                else if (!fl_hot_reg)
                begin
                    fl_hot_next  = 1'b1;
                    fl_rank_next = '0;
                end
                else
                begin
                    state_next = S_FL_END;
                end
            end
            S_FL_READ:
            begin
                if (!ram_rdata.dirty || out_free)
                begin
                    if (ram_rdata.dirty)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_WB;
                        ofile_next     = ram_rdata.file;
                        oblock_next    = ram_rdata.block;
                        oslot_next     = OUT_SLOT_W'(fl_slot_reg);
                        olast_next     = 1'b0;
                    end
                    // Step to the next list position.
                    if (fl_rank_reg == RANK_W'(NUM_ENTRIES - 1))
                    begin
                        fl_rank_next = '0;
                        if (fl_hot_reg)
                        begin
                            state_next = S_FL_END;
                        end
                        else
                        begin
                            fl_hot_next = 1'b1;
                            state_next  = S_FL_FIND;
                        end
                    end
                    else
                    begin
                        fl_rank_next = fl_rank_reg + 1'b1;
                        state_next   = S_FL_FIND;
                    end
                end
            end
            S_FL_END:
            begin
                if (fl_fetch_reg || cmd_reg == CMD_FLUSH)
                begin
                    lcmd.op = LOP_CLEAR;
                end
                state_next = fl_fetch_reg ? S_FETCH : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_DONE;
                    ofile_next     = '0;
                    oblock_next    = '0;
                    oslot_next     = '0;
                    olast_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmp_vld_reg   <= cmp_vld_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        file_reg      <= file_next;
        block_reg     <= block_next;
        scan_addr_reg <= scan_addr_next;
        cmp_slot_reg  <= cmp_slot_next;
        hit_slot_reg  <= hit_slot_next;
        hit_entry_reg <= hit_entry_next;
        fl_hot_reg    <= fl_hot_next;
        fl_rank_reg   <= fl_rank_next;
        fl_slot_reg   <= fl_slot_next;
        fl_fetch_reg  <= fl_fetch_next;
        kind_reg      <= kind_next;
        ofile_reg     <= ofile_next;
        oblock_reg    <= oblock_next;
        oslot_reg     <= oslot_next;
        olast_reg     <= olast_next;
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign out_file_id      = ofile_reg;
    assign out_block_offset = oblock_reg;
    assign slot             = oslot_reg;
    assign last             = olast_reg;

endmodule

// ----- sv/qbc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module qbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/qbc_list.sv -----
// Valid, list membership and rank of every slot, with the list updates.
// Depends on qbc_pkg.
module qbc_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qbc_pkg::list_cmd_t            lcmd,
    input  logic                          q_hot,
    input  logic [qbc_pkg::RANK_W-1:0]    q_rank,
    output logic                          q_found,
    output logic [qbc_pkg::SLOT_W-1:0]    q_slot,
    output logic [qbc_pkg::SLOT_W-1:0]    free_slot,
    output logic                          full,
    output logic [qbc_pkg::NUM_ENTRIES-1:0] valid_vec,
    output logic [qbc_pkg::NUM_ENTRIES-1:0] hot_vec
);
    import qbc_pkg::*;

    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [NUM_ENTRIES-1:0] hot_reg, hot_next;
    logic [RANK_W-1:0]      rank_reg [NUM_ENTRIES];
    logic [RANK_W-1:0]      rank_next [NUM_ENTRIES];

    // Next state of all slots for the requested list operation.
    always_comb
    begin
        logic              from_hot;
        logic [RANK_W-1:0] old_rank;
        from_hot   = hot_reg[lcmd.slot];
        old_rank   = rank_reg[lcmd.slot];
        valid_next = valid_reg;
        hot_next   = hot_reg;
        for (int t = 0; t < NUM_ENTRIES; t++)
        begin
            rank_next[t] = rank_reg[t];
            case (lcmd.op)
                LOP_MOVE:
                begin
                    if (SLOT_W'(t) == lcmd.slot)
                    begin
                        hot_next[t]  = lcmd.to_hot;
                        rank_next[t] = '0;
                    end
                    else if (valid_reg[t])
                    begin
                        if (hot_reg[t] == from_hot && rank_reg[t] > old_rank
                            && hot_reg[t] != lcmd.to_hot)
                        begin
                            rank_next[t] = rank_reg[t] - 1'b1;
                        end
                        else if (hot_reg[t] == lcmd.to_hot
                            && !(hot_reg[t] == from_hot && rank_reg[t] > old_rank))
                        begin
                            rank_next[t] = rank_reg[t] + 1'b1;
                        end
                    end
                end
                LOP_INSERT:
                begin
                    if (SLOT_W'(t) == lcmd.slot)
                    begin
                        valid_next[t] = 1'b1;
                        hot_next[t]   = 1'b0;
                        rank_next[t]  = '0;
                    end
                    else if (valid_reg[t] && !hot_reg[t])
                    begin
                        rank_next[t] = rank_reg[t] + 1'b1;
                    end
                end
                LOP_CLEAR:
                begin
                    valid_next[t] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control bits, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hot_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hot_reg   <= hot_next;
        end
    end

    // Ranks are only read for valid slots.
    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
    end

    // Slot at a given list position and lowest free slot.
    always_comb
    begin
        q_found   = 1'b0;
        q_slot    = '0;
        free_slot = '0;
        for (int t = NUM_ENTRIES - 1; t >= 0; t--)
        begin
            if (valid_reg[t] && hot_reg[t] == q_hot && rank_reg[t] == q_rank)
            begin
                q_found = 1'b1;
                q_slot  = SLOT_W'(t);
            end
            if (!valid_reg[t])
            begin
                free_slot = SLOT_W'(t);
            end
        end
    end

    assign full      = &valid_reg;
    assign valid_vec = valid_reg;
    assign hot_vec   = hot_reg;

endmodule

// ----- sv/qbc_checker.sv -----
// Port-level checks of the block cache tag unit, bound to the top level.
// Depends on qbc_pkg and two_queue_block_cache_tags_unit_assert.svh.
`include "two_queue_block_cache_tags_unit_assert.svh"

module qbc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [qbc_pkg::KIND_W-1:0]     kind,
    input logic [qbc_pkg::FILE_W-1:0]     out_file_id,
    input logic [qbc_pkg::BLOCK_W-1:0]    out_block_offset,
    input logic [qbc_pkg::OUT_SLOT_W-1:0] slot,
    input logic                           last
);
    import qbc_pkg::*;

    // A stalled result keeps its kind and slot.
    `QBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(slot), "result changed while stalled")

    // A command-done result carries no block.
    `QBC_ASSERT_NOW(a_done_zero, out_valid && kind == KIND_DONE, out_file_id == '0 && out_block_offset == '0 && slot == '0 && last, "bad command-done result")

    // Hits and fetches always end their request.
    `QBC_ASSERT_NOW(a_hit_last, out_valid && (kind == KIND_HIT || kind == KIND_FETCH), last, "hit or fetch not marked last")

    // A writeback is never the final result of a request.
    `QBC_ASSERT_NOW(a_wb_not_last, out_valid && kind == KIND_WB, !last, "writeback marked last")

endmodule

bind two_queue_block_cache_tags_unit qbc_checker u_qbc_checker (.*);
